/* hdl/didct_pkg.sv */
package didct_pkg;

  localparam int FRAC_BITS = 13;
  localparam int SHIFT_COL = 11;
  localparam int SHIFT_ROW = 18;

  localparam logic signed [15:0] K_0_298 = 16'sd2446;
  localparam logic signed [15:0] K_0_390 = 16'sd3196;
  localparam logic signed [15:0] K_0_541 = 16'sd4433;
  localparam logic signed [15:0] K_0_765 = 16'sd6270;
  localparam logic signed [15:0] K_0_899 = 16'sd7373;
  localparam logic signed [15:0] K_1_175 = 16'sd9633;
  localparam logic signed [15:0] K_1_501 = 16'sd12299;
  localparam logic signed [15:0] K_1_847 = 16'sd15137;
  localparam logic signed [15:0] K_1_961 = 16'sd16069;
  localparam logic signed [15:0] K_2_053 = 16'sd16819;
  localparam logic signed [15:0] K_2_562 = 16'sd20995;
  localparam logic signed [15:0] K_3_072 = 16'sd25172;

  // Handoff from the load front to the transform back: one finished block.
  typedef struct packed {
    logic req;
  } blk_req_t;

  typedef struct packed {
    logic busy;
  } blk_stat_t;

endpackage

/* hdl/didct_pass.sv */
// One 8-point islow inverse DCT, evaluated step by step with a
// single shared multiplier. Inputs are sampled on go; done pulses when
// all eight outputs are valid.
module didct_pass (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic                row_pass,
  input  logic signed [15:0]  vin [8],
  output logic signed [15:0]  vout [8],
  output logic                done
);
  import didct_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'd15;

  logic               run;
  logic [4:0]         step;
  logic signed [15:0] x [8];
  logic               rp;
  logic signed [31:0] prod;
  logic signed [15:0] ma_op;
  logic signed [15:0] mb_op;
  logic signed [31:0] p [14];
  logic signed [31:0] rnd;

  logic signed [15:0] za, zb, zc, zd, s04p, s04m;

  assign za   = x[7] + x[1];
  assign zb   = x[5] + x[3];
  assign zc   = x[7] + x[3];
  assign zd   = x[5] + x[1];
  assign s04p = x[0] + x[4];
  assign s04m = x[0] - x[4];

  always_comb begin
    ma_op = '0;
    mb_op = '0;
    case (step)
      5'd0:  begin ma_op = x[2]; mb_op = K_0_541 + K_0_765; end
      5'd1:  begin ma_op = x[6]; mb_op = K_0_541; end
      5'd2:  begin ma_op = x[2]; mb_op = K_0_541; end
      5'd3:  begin ma_op = x[6]; mb_op = K_0_541 - K_1_847; end
      5'd4:  begin ma_op = zc;   mb_op = K_1_175; end
      5'd5:  begin ma_op = zd;   mb_op = K_1_175; end
      5'd6:  begin ma_op = za;   mb_op = -K_0_899; end
      5'd7:  begin ma_op = zb;   mb_op = -K_2_562; end
      5'd8:  begin ma_op = zc;   mb_op = -K_1_961; end
      5'd9:  begin ma_op = zd;   mb_op = -K_0_390; end
      5'd10: begin ma_op = x[7]; mb_op = K_0_298; end
      5'd11: begin ma_op = x[5]; mb_op = K_2_053; end
      5'd12: begin ma_op = x[3]; mb_op = K_3_072; end
      5'd13: begin ma_op = x[1]; mb_op = K_1_501; end
      default: begin ma_op = '0; mb_op = '0; end
    endcase
  end

  assign prod = 32'(ma_op * mb_op);
  assign rnd  = rp ? 32'sd131072 : 32'sd1024;

  always_ff @(posedge clk) begin
    if (go) begin
      x  <= vin;
      rp <= row_pass;
    end
    if (run && step < 5'd14) begin
      p[step[3:0]] <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
    end else if (go) begin
      run  <= 1'b1;
      step <= '0;
    end else if (run) begin
      if (step == LAST_STEP) begin
        run <= 1'b0;
      end
      step <= step + 5'd1;
    end
  end

  // Final combination; captured on the step after the last product, from registered products.
  logic signed [31:0] e0, e1, e2, e3, s10, s11, s12, s13, z5, mc, md;
  logic signed [31:0] o4, o5, o6, o7;
  logic signed [31:0] w [8];

  function automatic logic signed [15:0] desc(input logic signed [31:0] v,
                                               input logic r);
    logic signed [31:0] t;
    begin
      t = r ? (v >>> SHIFT_ROW) : (v >>> SHIFT_COL);
      if (t > 32'sd32767) desc = 16'sh7fff;
      else if (t < -32'sd32768) desc = 16'sh8000;
      else desc = t[15:0];
    end
  endfunction

  always_comb begin
    e3  = p[0] + p[1];
    e2  = p[2] + p[3];
    e0  = (32'(s04p) <<< FRAC_BITS) + rnd;
    e1  = (32'(s04m) <<< FRAC_BITS) + rnd;
    s10 = e0 + e3;
    s13 = e0 - e3;
    s11 = e1 + e2;
    s12 = e1 - e2;
    z5  = p[4] + p[5];
    mc  = p[8] + z5;
    md  = p[9] + z5;
    o4  = p[10] + p[6] + mc;
    o5  = p[11] + p[7] + md;
    o6  = p[12] + p[7] + mc;
    o7  = p[13] + p[6] + md;
    w[0] = s10 + o7;
    w[7] = s10 - o7;
    w[1] = s11 + o6;
    w[6] = s11 - o6;
    w[2] = s12 + o5;
    w[5] = s12 - o5;
    w[3] = s13 + o4;
    w[4] = s13 - o4;
  end

  always_ff @(posedge clk) begin
    if (run && step == 5'd14) begin
      for (int i = 0; i < 8; i++) begin
        vout[i] <= desc(w[i], rp);
      end
    end
  end

  assign done = run && step == LAST_STEP;

endmodule

/* hdl/didct_front.sv */
// Load front: dequantizes each coefficient and writes it to the
// coefficient memory; hands a block to the back end after the 64th.
module didct_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic signed [15:0]   coefficient,
  input  logic [14:0]          quant_value,
  input  logic [5:0]           rd_addr,
  output logic signed [15:0]   rd_data,
  output didct_pkg::blk_req_t  req
);
  import didct_pkg::*;

  logic [15:0] mem [64];
  logic [5:0]  load_count;
  logic [30:0] prod;

  assign prod = 31'($unsigned(coefficient)) * 31'(quant_value);

  always_ff @(posedge clk) begin
    if (load) begin
      mem[load_count] <= prod[15:0];
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      req.req    <= 1'b0;
    end else begin
      req.req <= load && load_count == 6'd63;
      if (load) begin
        load_count <= load_count + 6'd1;
      end
    end
  end

endmodule

/* hdl/didct_back.sv */
// Transform back end: column pass into the work memory, then row pass,
// level shift and clamp, one sample a cycle out while a row is emitted.
module didct_back (
  input  logic                  clk,
  input  logic                  rst,
  input  didct_pkg::blk_req_t   req,
  output logic [5:0]            rd_addr,
  input  logic signed [15:0]    rd_data,
  output didct_pkg::blk_stat_t  stat,
  output logic [7:0]            sample,
  output logic                  last,
  output logic                  strobe
);
  import didct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_WRIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state;
  logic               row_pass;
  logic [2:0]         line;
  logic [3:0]         cnt;
  logic signed [15:0] vin [8];
  logic signed [15:0] vout [8];
  logic               go;
  logic               done;
  logic [15:0]        work [64];
  logic signed [15:0] wrd;
  logic signed [15:0] level;

  didct_pass u_pass (
    .clk(clk), .rst(rst), .go(go), .row_pass(row_pass),
    .vin(vin), .vout(vout), .done(done)
  );

  // Column pass reads down a column; row pass reads along a row.
  always_comb begin
    if (row_pass) rd_addr = {line, cnt[2:0]};
    else rd_addr = {cnt[2:0], line};
  end

  always_ff @(posedge clk) begin
    wrd <= work[rd_addr];
    if (state == S_WRIT) begin
      work[{cnt[2:0], line}] <= vout[cnt[2:0]];
    end
  end

  // The eighth operand lands at cnt 8, so the pass is started in the cycle after, at cnt 9.
  assign go    = state == S_READ && cnt == 4'd9;
  assign level = vout[cnt[2:0]] + 16'sd128;

  always_ff @(posedge clk) begin
    if (state == S_READ && cnt != 4'd0 && cnt != 4'd9) begin
      vin[cnt[2:0] - 3'd1] <= row_pass ? wrd : rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row_pass <= 1'b0;
      line     <= '0;
      cnt      <= '0;
      strobe   <= 1'b0;
      last     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.req) begin
            state    <= S_READ;
            row_pass <= 1'b0;
            line     <= '0;
            cnt      <= '0;
          end
        end
        S_READ: begin
          if (cnt == 4'd9) begin
            state <= S_CALC;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_CALC: begin
          if (done) begin
            state <= row_pass ? S_EMIT : S_WRIT;
            cnt   <= '0;
          end
        end
        S_WRIT, S_EMIT: begin
          if (state == S_EMIT) begin
            strobe <= 1'b1;
            last   <= line == 3'd7 && cnt == 4'd7;
            sample <= level < 0 ? 8'd0 : (level > 16'sd255 ? 8'd255 : level[7:0]);
          end
          if (cnt == 4'd7) begin
            cnt <= '0;
            if (line == 3'd7) begin
              line <= '0;
              if (state == S_EMIT) begin
                state <= S_IDLE;
              end else begin
                row_pass <= 1'b1;
                state    <= S_READ;
              end
            end else begin
              line  <= line + 3'd1;
              state <= S_READ;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = state != S_IDLE;

endmodule

/* hdl/dequant_idct_8x8_islow.sv */
// Channel     | Ports                          | Handshake
// ------------+--------------------------------+----------------------------
// input       | coefficient, quant_value       | start high, busy low
// result      | sample, last                   | strobe, one cycle, no stall
//
// Input transactions may be given back to back while busy is low, loading a
// block of 64. After the 64th the block is busy for the transform: sixteen
// passes, each reading a line, computing it on one shared multiplier and then
// writing it back or emitting it; samples leave one per cycle at the end of
// each row pass.
// Reset is synchronous and returns the load counter and sequencer to idle.
// The receiver cannot stall; samples are presented for one cycle only.
module dequant_idct_8x8_islow (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] coefficient,
  input  logic [14:0]        quant_value,
  output logic [7:0]         sample,
  output logic               last,
  output logic               strobe
);
  import didct_pkg::*;

  blk_req_t           req;
  blk_stat_t          stat;
  logic [5:0]         rd_addr;
  logic signed [15:0] rd_data;
  logic               load;

  // The front is held off while a finished block is being transformed.
  assign load = start && !busy;
  assign busy = stat.busy || req.req;

  didct_front u_front (
    .clk(clk), .rst(rst), .load(load), .coefficient(coefficient),
    .quant_value(quant_value), .rd_addr(rd_addr), .rd_data(rd_data), .req(req)
  );

  didct_back u_back (
    .clk(clk), .rst(rst), .req(req), .rd_addr(rd_addr), .rd_data(rd_data),
    .stat(stat), .sample(sample), .last(last), .strobe(strobe)
  );

`ifndef SYNTH
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe) else $error("last without strobe");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("sample while idle");
  a_req_pulse: assert property (@(posedge clk) disable iff (rst)
    req.req |=> !req.req) else $error("request held");
`endif

endmodule
